// ===== rtl/dtt_pkg.sv =====
// ---------------------------------------------------------------------------
// Detection target tracker package
// Shared codes, widths and the result record of the target tracker.
// ---------------------------------------------------------------------------
package dtt_pkg;

  // Limits of one frame and of the coordinate fields.
  localparam int MAX_BOXES = 64;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int BOX_W     = 13;
  localparam int COORD_W   = 12;
  localparam int AREA_W    = 24;
  localparam int TIME_W    = 32;
  localparam int TMO_W     = 16;
  localparam int CONF_W    = 11;
  localparam int CFG_W     = 24;

  // Confidence of exactly 1.0 in unsigned Q1.10.
  localparam logic [CONF_W-1:0] CONF_ONE = 11'd1024;

  // Item opcodes.
  localparam logic [1:0] OP_BOX    = 2'd0;
  localparam logic [1:0] OP_FRAME  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_CANCEL = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MIN_AREA     = 2'd2;
  localparam logic [1:0] REG_LOST_TIMEOUT = 2'd3;

  // Tracker state codes as reported on track_state.
  localparam logic [2:0] TS_IDLE      = 3'd0;
  localparam logic [2:0] TS_ACQUIRING = 3'd1;
  localparam logic [2:0] TS_TRACKING  = 3'd2;
  localparam logic [2:0] TS_LOST      = 3'd3;
  localparam logic [2:0] TS_COOLDOWN  = 3'd4;

  // One result beat.
  typedef struct packed {
    logic [2:0]         track_state;
    logic               target_active;
    logic               fresh_target;
    logic               lost_event;
    logic [TIME_W-1:0]  track_duration_ms;
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
    logic [IDX_W-1:0]   target_index;
    logic [AREA_W-1:0]  target_area;
    logic               laser_on_request;
    logic               laser_off_home;
  } res_t;

endpackage

// ===== rtl/detection_target_tracker.sv =====
// A frame, tick or cancel beat gives a result, registered into the output buffer when the beat is accepted.
// Box beats give no result and only update the per-frame selection registers.
// Throughput: one beat per cycle; a two-entry output buffer lets input continue
// while one result waits, and in_ready drops only when both entries are full.
// Reset (synchronous, active high): state idle, no target, frame empty, registers
// at 640, 480, 100 and 500, output buffer empty.
// ---------------------------------------------------------------------------
// Detection target tracker
// Picks the largest valid detection box of each frame, tracks it over time
// and raises laser requests, loss and cancel events.
// ---------------------------------------------------------------------------
module detection_target_tracker (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [dtt_pkg::CFG_W-1:0]     cfg_data,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic signed [dtt_pkg::BOX_W-1:0] box_x,
  input  logic signed [dtt_pkg::BOX_W-1:0] box_y,
  input  logic signed [dtt_pkg::BOX_W-1:0] box_width,
  input  logic signed [dtt_pkg::BOX_W-1:0] box_height,
  input  logic [dtt_pkg::CONF_W-1:0]    confidence,
  input  logic [dtt_pkg::TIME_W-1:0]    time_ms,
  input  logic                          laser_armed,
  input  logic                          laser_firing,
  input  logic                          laser_cooling,
  // Output channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    track_state,
  output logic                          target_active,
  output logic                          fresh_target,
  output logic                          lost_event,
  output logic [dtt_pkg::TIME_W-1:0]    track_duration_ms,
  output logic [dtt_pkg::COORD_W-1:0]   centroid_x,
  output logic [dtt_pkg::COORD_W-1:0]   centroid_y,
  output logic [dtt_pkg::IDX_W-1:0]     target_index,
  output logic [dtt_pkg::AREA_W-1:0]    target_area,
  output logic                          laser_on_request,
  output logic                          laser_off_home
);

  typedef enum logic [2:0] {
    ST_IDLE      = dtt_pkg::TS_IDLE,
    ST_ACQUIRING = dtt_pkg::TS_ACQUIRING,
    ST_TRACKING  = dtt_pkg::TS_TRACKING,
    ST_COOLDOWN  = dtt_pkg::TS_COOLDOWN
  } state_t;

  // Configuration registers.
  logic [dtt_pkg::COORD_W-1:0] frame_width;
  logic [dtt_pkg::COORD_W-1:0] frame_height;
  logic [dtt_pkg::AREA_W-1:0]  min_area;
  logic [dtt_pkg::TMO_W-1:0]   lost_timeout_ms;

  // Tracking state.
  state_t                      state, state_next;
  logic                        tracking, tracking_next;
  logic [dtt_pkg::TIME_W-1:0]  track_start;
  logic [dtt_pkg::TIME_W-1:0]  sight_time;

  // Per-frame selection.
  logic [dtt_pkg::AREA_W-1:0]  top_area;
  logic [dtt_pkg::IDX_W-1:0]   best_slot;
  logic                        best_found;
  logic [dtt_pkg::COORD_W-1:0] best_cx;
  logic [dtt_pkg::COORD_W-1:0] best_cy;
  logic [dtt_pkg::CNT_W-1:0]   boxes_seen;

  // Output buffer: main register and skid entry.
  dtt_pkg::res_t               out_res, skid_res, res_next;
  logic                        skid_valid;
  logic                        has_result;

  logic                        in_beat;
  logic                        drain;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_beat   = in_valid && in_ready;
  assign drain     = out_valid && out_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= 12'd640;
      frame_height    <= 12'd480;
      min_area        <= 24'd100;
      lost_timeout_ms <= 16'd500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dtt_pkg::REG_FRAME_WIDTH:  frame_width     <= cfg_data[dtt_pkg::COORD_W-1:0];
        dtt_pkg::REG_FRAME_HEIGHT: frame_height    <= cfg_data[dtt_pkg::COORD_W-1:0];
        dtt_pkg::REG_MIN_AREA:     min_area        <= cfg_data[dtt_pkg::AREA_W-1:0];
        dtt_pkg::REG_LOST_TIMEOUT: lost_timeout_ms <= cfg_data[dtt_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Box checks: positive size, inside the frame, confidence at most 1.0.
  logic [dtt_pkg::COORD_W-1:0] bx, by, bw, bh;
  logic [dtt_pkg::COORD_W:0]   x_end, y_end;
  logic                        size_ok, pos_ok, fit_ok, conf_ok, box_ok, room;
  logic [dtt_pkg::AREA_W-1:0]  area, limit;
  logic                        take_box;

  assign bx = box_x[dtt_pkg::COORD_W-1:0];
  assign by = box_y[dtt_pkg::COORD_W-1:0];
  assign bw = box_width[dtt_pkg::COORD_W-1:0];
  assign bh = box_height[dtt_pkg::COORD_W-1:0];

  assign size_ok = !box_width[dtt_pkg::BOX_W-1] && (bw != '0) &&
                   !box_height[dtt_pkg::BOX_W-1] && (bh != '0);
  assign pos_ok  = !box_x[dtt_pkg::BOX_W-1] && (bx < frame_width) &&
                   !box_y[dtt_pkg::BOX_W-1] && (by < frame_height);
  assign x_end   = {1'b0, bx} + {1'b0, bw};
  assign y_end   = {1'b0, by} + {1'b0, bh};
  assign fit_ok  = (x_end <= {1'b0, frame_width}) && (y_end <= {1'b0, frame_height});
  assign conf_ok = confidence <= dtt_pkg::CONF_ONE;
  assign box_ok  = size_ok && pos_ok && fit_ok && conf_ok;
  assign room    = boxes_seen < dtt_pkg::CNT_W'(dtt_pkg::MAX_BOXES);

  assign area     = bw * bh;
  assign limit    = best_found ? top_area : min_area;
  assign take_box = room && box_ok && (area > limit);

  // Loss check against the timeout and elapsed track time.
  logic [dtt_pkg::TIME_W-1:0] since_seen, duration;
  logic                       timed_out;

  assign since_seen = time_ms - sight_time;
  assign duration   = time_ms - track_start;
  assign timed_out  = tracking &&
                      (since_seen > {{(dtt_pkg::TIME_W-dtt_pkg::TMO_W){1'b0}}, lost_timeout_ms});

  // Next tracker state and result of a frame, tick or cancel beat.
  logic   fresh;
  state_t mid_state;

  always_comb begin
    state_next    = state;
    tracking_next = tracking;
    res_next      = '0;
    has_result    = 1'b0;
    fresh         = !tracking;
    mid_state     = timed_out ? ST_IDLE : state;
    unique case (opcode)
      dtt_pkg::OP_BOX: begin
        has_result = 1'b0;
      end
      dtt_pkg::OP_FRAME: begin
        has_result = 1'b1;
        if (!best_found) begin
          if (timed_out) begin
            res_next.lost_event        = 1'b1;
            res_next.track_duration_ms = duration;
            res_next.laser_off_home    = 1'b1;
            tracking_next              = 1'b0;
            state_next                 = ST_IDLE;
          end
        end else begin
          if (fresh) begin
            state_next = ST_ACQUIRING;
          end
          tracking_next         = 1'b1;
          res_next.fresh_target = fresh;
          res_next.centroid_x   = best_cx;
          res_next.centroid_y   = best_cy;
          res_next.target_index = best_slot;
          res_next.target_area  = top_area;
          if (laser_armed) begin
            res_next.laser_on_request = !laser_firing && !laser_cooling;
            state_next                = ST_TRACKING;
          end
        end
      end
      dtt_pkg::OP_TICK: begin
        has_result = 1'b1;
        if (timed_out) begin
          res_next.lost_event        = 1'b1;
          res_next.track_duration_ms = duration;
          res_next.laser_off_home    = 1'b1;
          tracking_next              = 1'b0;
        end
        state_next = mid_state;
        if (mid_state == ST_TRACKING && laser_cooling) begin
          state_next = ST_COOLDOWN;
        end else if (mid_state == ST_COOLDOWN && !laser_cooling) begin
          if (tracking_next) begin
            state_next                = ST_TRACKING;
            res_next.laser_on_request = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      dtt_pkg::OP_CANCEL: begin
        has_result = 1'b1;
        if (tracking) begin
          res_next.track_duration_ms = duration;
        end
        res_next.laser_off_home = 1'b1;
        tracking_next           = 1'b0;
        state_next              = ST_IDLE;
      end
      default: ;
    endcase
    res_next.track_state   = state_next;
    res_next.target_active = tracking_next;
  end

  // Tracker state and per-frame selection registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tracking    <= 1'b0;
      track_start <= '0;
      sight_time  <= '0;
      best_found  <= 1'b0;
      boxes_seen  <= '0;
    end else if (in_beat) begin
      state    <= state_next;
      tracking <= tracking_next;
      if (opcode == dtt_pkg::OP_BOX) begin
        if (room) begin
          boxes_seen <= boxes_seen + 1'b1;
        end
        if (take_box) begin
          best_found <= 1'b1;
          top_area   <= area;
          best_slot  <= boxes_seen[dtt_pkg::IDX_W-1:0];
          best_cx    <= bx + (bw >> 1);
          best_cy    <= by + (bh >> 1);
        end
      end else if (opcode == dtt_pkg::OP_FRAME) begin
        if (best_found) begin
          if (fresh) begin
            track_start <= time_ms;
          end
          sight_time <= time_ms;
        end
        best_found <= 1'b0;
        boxes_seen <= '0;
      end
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (in_beat && has_result) begin
        out_res <= res_next;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_beat && has_result) begin
      if (!out_valid) begin
        out_res   <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign track_state       = out_res.track_state;
  assign target_active     = out_res.target_active;
  assign fresh_target      = out_res.fresh_target;
  assign lost_event        = out_res.lost_event;
  assign track_duration_ms = out_res.track_duration_ms;
  assign centroid_x        = out_res.centroid_x;
  assign centroid_y        = out_res.centroid_y;
  assign target_index      = out_res.target_index;
  assign target_area       = out_res.target_area;
  assign laser_on_request  = out_res.laser_on_request;
  assign laser_off_home    = out_res.laser_off_home;

endmodule

// ===== rtl/dtt_checker.sv =====
// ---------------------------------------------------------------------------
// Detection target tracker checker
// Port-level assertions on the tracker, attached to the top level by bind.
// ---------------------------------------------------------------------------
module dtt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  track_state,
  input logic                        target_active,
  input logic                        fresh_target,
  input logic                        lost_event,
  input logic                        laser_off_home,
  input logic [dtt_pkg::TIME_W-1:0]  track_duration_ms
);

  // The input side only stalls while a result is pending on the output.
  a_stall_needs_pending: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with no pending result");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(track_state) &&
      $stable(track_duration_ms))
    else $error("stalled result beat changed");

  // A loss leaves the tracker idle with the laser sent home.
  a_lost_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && lost_event |-> !target_active && laser_off_home &&
      track_state == dtt_pkg::TS_IDLE)
    else $error("loss beat not idle");

  // A new target is always active and acquiring or tracking.
  a_new_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && fresh_target |-> target_active && !lost_event &&
      (track_state == dtt_pkg::TS_ACQUIRING || track_state == dtt_pkg::TS_TRACKING))
    else $error("new target beat inconsistent");

endmodule

bind detection_target_tracker dtt_checker u_dtt_checker (.*);
